@@ hdl/tolerant_point_dedup_table_assert.svh @@
// Assertion macros for the tolerant point dedup table.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef TOLERANT_POINT_DEDUP_TABLE_ASSERT_SVH
`define TOLERANT_POINT_DEDUP_TABLE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TPDT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tpdt assertion failed");

// Next-cycle implication, checked outside reset.
`define TPDT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tpdt assertion failed");

`endif

@@ hdl/tpdt_pkg.sv @@
// Shared types and constants of the tolerant point dedup table.
// No dependencies.
package tpdt_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int COORD_W    = 32;
  localparam int TOL_W      = 31;
  localparam int CODE_W     = 11;
  localparam int STATUS_W   = 2;
  localparam int FIRST_CODE = 101;
  localparam int NUM_AXES   = 3;

  localparam logic [TOL_W-1:0]    TOL_RESET    = 31'd66;
  localparam logic [STATUS_W-1:0] STATUS_MATCH = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ADDED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic [CODE_W-1:0]   point_code;
    logic [STATUS_W-1:0] status;
  } result_t;

  // Token handed from cell to cell: one candidate entry under test.
  typedef struct packed {
    logic valid;
    logic near;   // every axis seen so far lies inside the tolerance
  } link_t;

endpackage

@@ hdl/tolerant_point_dedup_table.sv @@
// Top level of the tolerant point dedup table: scan control, point count,
// tolerance register and result register. Uses tpdt_pkg, tpdt_cell.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_data  (x, y, z)
//  out     | output    | out_valid/out_stall| out_data (point_code, status)
//  cfg     | input     | cfg_we             | cfg_wdata (tolerance)
//
// An item takes the accept step, then one candidate enters the x/y/z cell
// chain per cycle (one read of each column RAM) until the last one leaves
// the chain, then the decide step; a match stops the scan early, and an
// empty table skips the scan and goes from accept straight to decide.
// Reset clears the count and restores the tolerance; the column RAMs need
// no clearing. A stalled result holds in its register; the next item is
// taken meanwhile and waits only in the decide step.
module tolerant_point_dedup_table #(
  parameter int MAX_POINTS = tpdt_pkg::MAX_POINTS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  tpdt_pkg::point_t           in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output tpdt_pkg::result_t          out_data,
  input  logic                       cfg_we,
  input  logic [tpdt_pkg::TOL_W-1:0] cfg_wdata
);

  `include "tolerant_point_dedup_table_assert.svh"

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int NA = tpdt_pkg::NUM_AXES;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_DECIDE = 3'b100
  } state_t;

  state_t                     state;
  logic [tpdt_pkg::TOL_W-1:0] tol;
  logic [CW-1:0]              count;
  logic [CW-1:0]              count_m1;
  logic [CW-1:0]              issue_idx;
  logic                       hit;
  logic [AW-1:0]              hit_idx;
  logic                       res_valid;
  tpdt_pkg::result_t          res;

  logic                       in_xfer;
  logic                       out_xfer;
  logic                       chain_hit;
  logic                       chain_last;
  logic                       kill;
  logic                       res_free;
  logic                       wr_en;
  logic [31:0]                code_sum;

  tpdt_pkg::link_t                     link  [NA+1];
  logic [AW-1:0]                       idx   [NA+1];
  logic signed [tpdt_pkg::COORD_W-1:0] coord [NA];

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = res_valid && !out_stall;
  assign in_stall = (state != S_IDLE);
  assign res_free = !res_valid || !out_stall;

  assign count_m1   = count - CW'(1);
  assign chain_hit  = (state == S_SCAN) && link[NA].valid && link[NA].near;
  assign chain_last = (state == S_SCAN) && link[NA].valid &&
                      (idx[NA] == count_m1[AW-1:0]);
  assign kill       = chain_hit;

  // Feed one candidate index per cycle into the first cell.
  assign link[0].valid = (state == S_SCAN) && (issue_idx < count) && !chain_hit;
  assign link[0].near  = 1'b1;
  assign idx[0]        = issue_idx[AW-1:0];

  assign coord[0] = in_data.x;
  assign coord[1] = in_data.y;
  assign coord[2] = in_data.z;

  assign wr_en = (state == S_DECIDE) && res_free && !hit &&
                 (count != CW'(MAX_POINTS));

  for (genvar a = 0; a < NA; a++) begin : g_cell
    tpdt_cell #(
      .DEPTH(MAX_POINTS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .load    (in_xfer),
      .coord   (coord[a]),
      .tol     (tol),
      .wr_en   (wr_en),
      .wr_addr (count[AW-1:0]),
      .kill    (kill),
      .link_in (link[a]),
      .idx_in  (idx[a]),
      .link_out(link[a+1]),
      .idx_out (idx[a+1])
    );
  end

  always_comb begin
    if (hit) begin
      code_sum = 32'(tpdt_pkg::FIRST_CODE) + 32'(hit_idx);
    end else begin
      code_sum = 32'(tpdt_pkg::FIRST_CODE) + 32'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= tpdt_pkg::TOL_RESET;
    end else if (cfg_we) begin
      tol <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      issue_idx <= '0;
      hit       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (state == S_DECIDE && res_free) begin
        res_valid <= 1'b1;
      end else if (out_xfer) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            issue_idx <= '0;
            hit       <= 1'b0;
            state     <= (count == '0) ? S_DECIDE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (link[0].valid) begin
            issue_idx <= issue_idx + CW'(1);
          end
          if (chain_hit) begin
            hit   <= 1'b1;
            state <= S_DECIDE;
          end else if (chain_last) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (res_free) begin
            state <= S_IDLE;
            if (wr_en) begin
              count <= count + CW'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers: the first hit index and the result.
  always_ff @(posedge clk) begin
    if (chain_hit) begin
      hit_idx <= idx[NA];
    end
    if (state == S_DECIDE && res_free) begin
      if (hit) begin
        res.point_code <= code_sum[tpdt_pkg::CODE_W-1:0];
        res.status     <= tpdt_pkg::STATUS_MATCH;
      end else if (count == CW'(MAX_POINTS)) begin
        res.point_code <= '0;
        res.status     <= tpdt_pkg::STATUS_FULL;
      end else begin
        res.point_code <= code_sum[tpdt_pkg::CODE_W-1:0];
        res.status     <= tpdt_pkg::STATUS_ADDED;
      end
    end
  end

  assign out_valid = res_valid;
  assign out_data  = res;

  `TPDT_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(MAX_POINTS))
  `TPDT_ASSERT_NOW(a_chain_in_scan, link[NA].valid, state == S_SCAN)
  `TPDT_ASSERT_NEXT(a_append_counts, wr_en, count == $past(count) + CW'(1))
  `TPDT_ASSERT_NEXT(a_accept_leaves_idle, in_xfer, state != S_IDLE)

endmodule

@@ hdl/tpdt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tpdt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/tpdt_cell.sv @@
// One axis cell: holds one coordinate column and the query coordinate,
// tests one candidate per cycle and hands the token on. Uses tpdt_pkg, tpdt_ram.
module tpdt_cell #(
  parameter int DEPTH = tpdt_pkg::MAX_POINTS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  logic signed [tpdt_pkg::COORD_W-1:0] coord,
  input  logic [tpdt_pkg::TOL_W-1:0]          tol,
  input  logic                                wr_en,
  input  logic [$clog2(DEPTH)-1:0]            wr_addr,
  input  logic                                kill,
  input  tpdt_pkg::link_t                     link_in,
  input  logic [$clog2(DEPTH)-1:0]            idx_in,
  output tpdt_pkg::link_t                     link_out,
  output logic [$clog2(DEPTH)-1:0]            idx_out
);

  localparam int AW = $clog2(DEPTH);
  localparam int DW = tpdt_pkg::COORD_W + 1;

  logic signed [tpdt_pkg::COORD_W-1:0] q;
  logic [tpdt_pkg::COORD_W-1:0]        stored;
  tpdt_pkg::link_t                     a_link;
  logic [AW-1:0]                       a_idx;
  logic signed [DW-1:0]                diff;
  logic signed [DW-1:0]                tol_pos;
  logic signed [DW-1:0]                tol_neg;
  logic                                match;

  tpdt_ram #(
    .WIDTH(tpdt_pkg::COORD_W),
    .DEPTH(DEPTH)
  ) u_col (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(q),
    .raddr(idx_in),
    .rdata(stored)
  );

  always_ff @(posedge clk) begin
    if (load) begin
      q <= coord;
    end
  end

  // Exact difference in one extra bit, open interval on both sides.
  always_comb begin
    diff    = {q[tpdt_pkg::COORD_W-1], q} -
              {stored[tpdt_pkg::COORD_W-1], stored};
    tol_pos = {2'b00, tol};
    tol_neg = -tol_pos;
    match   = (diff < tol_pos) && (diff > tol_neg);
  end

  always_ff @(posedge clk) begin
    if (rst || kill) begin
      a_link   <= '0;
      link_out <= '0;
    end else begin
      a_link         <= link_in;
      link_out.valid <= a_link.valid;
      link_out.near  <= a_link.near & match;
    end
    a_idx   <= idx_in;
    idx_out <= a_idx;
  end

endmodule

@@ tb/tolerant_point_dedup_table_test.sv @@
// Self-checking testbench for tolerant_point_dedup_table: random and directed points,
// a scoreboard class that predicts the code and status of each point, and random idling.
// Depends on tpdt_pkg and the tolerant_point_dedup_table RTL.
module tolerant_point_dedup_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W    = tpdt_pkg::COORD_W;
  localparam int TOL_W      = tpdt_pkg::TOL_W;
  localparam int CODE_W     = tpdt_pkg::CODE_W;
  localparam int MAX_POINTS = tpdt_pkg::MAX_POINTS;

  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic [TOL_W-1:0]          TOL_MAX   = 31'h7FFF_FFFF;
  localparam int                        RANDOM_PHASES = 6;
  localparam int                        PHASE_ITEMS   = 86;

  class weld_scoreboard;
    tpdt_pkg::point_t  stored_pts[MAX_POINTS];
    int unsigned       stored_count;
    logic [TOL_W-1:0]  tolerance;
    tpdt_pkg::result_t expected_results[$];
    int                mismatches;

    function new();
      stored_count = 0;
      tolerance = tpdt_pkg::TOL_RESET;
      mismatches = 0;
    endfunction

    // Open interval, difference taken in 64 bits so nothing wraps.
    function bit axis_near(logic signed [COORD_W-1:0] a,
                           logic signed [COORD_W-1:0] s);
      longint diff;
      longint lim;
      diff = longint'(a) - longint'(s);
      lim = longint'(tolerance);
      return (diff > -lim) && (diff < lim);
    endfunction

    // Search in insertion order, else append, else report full.
    function void weld_point(tpdt_pkg::point_t p);
      tpdt_pkg::result_t r;
      bit                found;
      int unsigned       i;
      found = 1'b0;
      for (i = 0; i < stored_count && !found; i++) begin
        if (axis_near(p.x, stored_pts[i].x) && axis_near(p.y, stored_pts[i].y) &&
            axis_near(p.z, stored_pts[i].z)) begin
          found = 1'b1;
          r.point_code = CODE_W'(tpdt_pkg::FIRST_CODE + i);
          r.status = tpdt_pkg::STATUS_MATCH;
        end
      end
      if (!found) begin
        if (stored_count >= MAX_POINTS) begin
          r.point_code = '0;
          r.status = tpdt_pkg::STATUS_FULL;
        end else begin
          stored_pts[stored_count] = p;
          r.point_code = CODE_W'(tpdt_pkg::FIRST_CODE + stored_count);
          r.status = tpdt_pkg::STATUS_ADDED;
          stored_count++;
        end
      end
      expected_results.push_back(r);
    endfunction

    task flag_mismatch(string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(tpdt_pkg::result_t got);
      tpdt_pkg::result_t want;
      if (expected_results.size() == 0) begin
        flag_mismatch($sformatf("result code %0d status %0d with nothing pending",
                                got.point_code, got.status));
        return;
      end
      want = expected_results.pop_front();
      if (got.point_code !== want.point_code)
        flag_mismatch($sformatf("point_code got %0d want %0d",
                                got.point_code, want.point_code));
      if (got.status !== want.status)
        flag_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  tpdt_pkg::point_t  in_data;
  logic              out_valid;
  logic              out_stall = 1'b0;
  tpdt_pkg::result_t out_data;
  logic              cfg_we;
  logic [TOL_W-1:0]  cfg_wdata;

  weld_scoreboard sb = new();
  bit             quiet = 1'b0;
  bit             calm = 1'b0;
  int             stall_left = 0;

  tolerant_point_dedup_table #(
    .MAX_POINTS(MAX_POINTS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: stall in bursts of random length.
  always @(posedge clk) begin
    if (rst || quiet || calm) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 13);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(out_data);
    end
  end

  function automatic tpdt_pkg::point_t pt(logic signed [COORD_W-1:0] x,
                                          logic signed [COORD_W-1:0] y,
                                          logic signed [COORD_W-1:0] z);
    tpdt_pkg::point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    return p;
  endfunction

  // Land on, just inside, on or just past the tolerance boundary of s.
  function automatic logic signed [COORD_W-1:0] near_coord(logic signed [COORD_W-1:0] s,
                                                           logic [TOL_W-1:0] t);
    longint off;
    case ($urandom_range(0, 5))
      0: off = 0;
      1: off = t;
      2: off = (t == 0) ? 0 : t - 1;
      3: off = $urandom_range(0, t);
      4: off = longint'(t) + 1;
      default: off = longint'(t) + $urandom_range(0, 1000);
    endcase
    if ($urandom_range(0, 1) == 1) off = -off;
    return COORD_W'(longint'(s) + off);
  endfunction

  function automatic logic signed [COORD_W-1:0] extreme_coord();
    case ($urandom_range(0, 6))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return 32'sd0;
      3: return -32'sd1;
      4: return 32'sd1;
      5: return COORD_MIN + 32'sd1;
      default: return COORD_MAX - 32'sd1;
    endcase
  endfunction

  function automatic tpdt_pkg::point_t pick_point();
    tpdt_pkg::point_t p;
    tpdt_pkg::point_t base;
    int               kind;
    logic [TOL_W-1:0] t;
    kind = $urandom_range(0, 9);
    t = sb.tolerance;
    if (sb.stored_count != 0 && kind <= 4) begin
      base = sb.stored_pts[$urandom_range(0, sb.stored_count - 1)];
      if (kind == 4) begin
        p = base;
      end else begin
        p = pt(near_coord(base.x, t), near_coord(base.y, t), near_coord(base.z, t));
      end
    end else if (kind == 7) begin
      p = pt(extreme_coord(), extreme_coord(), extreme_coord());
    end else if (kind >= 8) begin
      // Keep a cluster near the origin so neighbors collide.
      p = pt($urandom_range(0, 1 << 19) - (1 << 18), $urandom_range(0, 1 << 19) - (1 << 18),
             $urandom_range(0, 1 << 19) - (1 << 18));
    end else begin
      p = pt($urandom, $urandom, $urandom);
    end
    return p;
  endfunction

  // Hold the point until the transfer, then predict its result.
  task automatic send_point(tpdt_pkg::point_t p);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (in_stall);
    sb.weld_point(p);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_tolerance(logic [TOL_W-1:0] v);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.tolerance = v;
  endtask

  initial begin
    logic [TOL_W-1:0] tol_plan[RANDOM_PHASES];
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset tolerance: exact hit, just inside, just outside, corners.
    send_point(pt(0, 0, 0));
    send_point(pt(0, 0, 0));
    send_point(pt(65, -65, 65));
    send_point(pt(66, 0, 0));
    send_point(pt(0, -66, 0));
    send_point(pt(COORD_MIN, COORD_MIN, COORD_MIN));
    send_point(pt(COORD_MAX, COORD_MAX, COORD_MAX));
    send_point(pt(COORD_MIN + 32'sd65, COORD_MIN, COORD_MIN + 32'sd1));
    send_point(pt(COORD_MAX - 32'sd65, COORD_MAX, COORD_MAX));
    send_point(pt(COORD_MAX, COORD_MIN, 0));
    send_point(pt(-1, 1, -1));
    // Zero tolerance: even an exact copy is new.
    set_tolerance('0);
    send_point(pt(0, 0, 0));
    send_point(pt(COORD_MAX, COORD_MAX, COORD_MAX));
    // Tolerance of one: only exact copies match.
    set_tolerance(31'd1);
    send_point(pt(0, 0, 0));
    send_point(pt(1, 0, 0));
    set_tolerance(TOL_MAX);
    send_point(pt(COORD_MIN, COORD_MIN, COORD_MIN));
    send_point(pt(COORD_MAX, COORD_MAX, COORD_MAX));
    send_point(pt(COORD_MAX, 0, COORD_MIN));
    send_point(pt(-1, -1, -1));

    tol_plan[0] = TOL_W'($urandom_range(2, 300));
    tol_plan[1] = 31'd1;
    tol_plan[2] = TOL_MAX;
    tol_plan[3] = '0;
    tol_plan[4] = TOL_W'($urandom_range(1 << 16, 1 << 24));
    tol_plan[5] = TOL_W'($urandom_range(1, 4096));
    foreach (tol_plan[ph]) begin
      set_tolerance(tol_plan[ph]);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 59) == 0) settle();
        send_point(pick_point());
      end
    end

    // Last stretch with no idling: a repeat of the newest point, a far corner
    // and random points.
    set_tolerance(TOL_W'($urandom_range(100, 100000)));
    quiet = 1'b1;
    calm = 1'b1;
    send_point(sb.stored_pts[sb.stored_count-1]);
    send_point(pt(COORD_MAX, COORD_MIN, COORD_MAX));
    repeat (40) send_point(pick_point());

    settle();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // A full-table search is the slowest item, so allow several times the slowest run.
  initial begin
    #100_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
